// File: rtl/core/tip_pkg.sv
// Shared types, character codes and digit decode for the text-to-integer parser.
package tip_pkg;

  // Input word: one character of the text.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } tip_in_t;

  // Output word: one finished conversion.
  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed_count;
  } tip_out_t;

  // Configuration register indexes.
  localparam logic [0:0] CFG_NUMBER_BASE = 1'd0;
  localparam logic [0:0] CFG_SIGNED_MODE = 1'd1;

  typedef struct packed {
    logic [5:0] number_base;
    logic       signed_mode;
  } tip_cfg_t;

  typedef enum logic [2:0] {
    PH_WS1    = 3'd0,
    PH_SIGN   = 3'd1,
    PH_WS2    = 3'd2,
    PH_PLUS2  = 3'd3,
    PH_PREFIX = 3'd4,
    PH_ZERO   = 3'd5,
    PH_DIGITS = 3'd6,
    PH_STOP   = 3'd7
  } tip_phase_t;

  // What one character does to the datapath.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CONSUME = 3'd1,
    ACT_MINUS   = 3'd2,
    ACT_ZERO    = 3'd3,
    ACT_HEX     = 3'd4,
    ACT_DIGIT   = 3'd5
  } tip_act_t;

  typedef struct packed {
    tip_phase_t phase;
    logic       count_zero;
  } tip_status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } tip_digit_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_HEX = 6'd16;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [7:0] LETTER_OFFSET = 8'd10;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  // Map 0-9, a-z, A-Z to 0..35.
  function automatic tip_digit_t digit_of(input logic [7:0] c);
    tip_digit_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      r.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + LETTER_OFFSET;
      r.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + LETTER_OFFSET;
      r.ok = 1'b1;
    end
    r.val = t[5:0];
    return r;
  endfunction

endpackage

// File: rtl/core/tip_in_reg.sv
// Input register stage: holds one accepted character word until the parser takes it.
module tip_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tip_pkg::tip_in_t in_data,
  input  logic            advance,
  output logic            q_valid,
  output tip_pkg::tip_in_t q_data
);
  import tip_pkg::*;

  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= in_data;
    end
  end

endmodule

// File: rtl/core/tip_parse.sv
// Parse state and combinational character step: phase, base, accumulator, sign, count.
module tip_parse #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tip_pkg::tip_in_t  item,
  input  tip_pkg::tip_cfg_t cfg,
  output tip_pkg::tip_out_t result,
  output tip_pkg::tip_status_t status
);
  import tip_pkg::*;

  tip_phase_t             phase;
  logic [5:0]             active_base;
  logic [VALUE_WIDTH-1:0] accumulator;
  logic                   negate_flag;
  logic [COUNT_WIDTH-1:0] char_count;

  tip_phase_t             phase_next;
  logic [5:0]             active_base_next;
  logic [VALUE_WIDTH-1:0] accumulator_next;
  logic                   negate_flag_next;
  logic [COUNT_WIDTH-1:0] char_count_next;

  tip_act_t   act;
  logic [5:0] digit_base;
  tip_digit_t dig;
  logic [5:0] clamped_base;

  logic [VALUE_WIDTH-1:0] final_value;
  logic [31:0]            count_wide;

  assign dig          = digit_of(item.character);
  assign clamped_base = (cfg.number_base > BASE_MAX) ? BASE_MAX : cfg.number_base;

  // Phase walk: a character may fall through several phases in a single step.
  always_comb begin
    tip_phase_t p;
    logic       done;
    p                = phase;
    done             = 1'b0;
    phase_next       = phase;
    act              = ACT_NONE;
    digit_base       = active_base;
    active_base_next = active_base;

    if (p == PH_WS1) begin
      if (is_space(item.character)) begin
        act  = ACT_CONSUME;
        done = 1'b1;
      end else begin
        p = PH_SIGN;
      end
    end

    if (!done && p == PH_SIGN) begin
      if (cfg.signed_mode) begin
        if (item.character == CH_MINUS) begin
          act        = ACT_MINUS;
          phase_next = PH_WS2;
          done       = 1'b1;
        end else if (item.character == CH_PLUS) begin
          act        = ACT_CONSUME;
          phase_next = PH_WS2;
          done       = 1'b1;
        end else begin
          p = PH_WS2;
        end
      end else if (item.character == CH_PLUS) begin
        act        = ACT_CONSUME;
        phase_next = PH_PREFIX;
        done       = 1'b1;
      end else begin
        p = PH_PREFIX;
      end
    end

    if (!done && p == PH_WS2) begin
      if (is_space(item.character)) begin
        act        = ACT_CONSUME;
        phase_next = PH_WS2;
        done       = 1'b1;
      end else begin
        p = PH_PLUS2;
      end
    end

    if (!done && p == PH_PLUS2) begin
      if (item.character == CH_PLUS) begin
        act        = ACT_CONSUME;
        phase_next = PH_PREFIX;
        done       = 1'b1;
      end else begin
        p = PH_PREFIX;
      end
    end

    // Latch the base here; a leading zero may still turn into a 0x prefix.
    if (!done && p == PH_PREFIX) begin
      if (item.character == CH_0 &&
          (clamped_base == '0 || clamped_base == BASE_HEX)) begin
        act              = ACT_ZERO;
        active_base_next = clamped_base;
        phase_next       = PH_ZERO;
        done             = 1'b1;
      end else begin
        digit_base       = (clamped_base == '0) ? BASE_DEC : clamped_base;
        active_base_next = digit_base;
        p                = PH_DIGITS;
      end
    end

    if (!done && p == PH_ZERO) begin
      if (item.character == CH_LX || item.character == CH_UX) begin
        act              = ACT_HEX;
        active_base_next = BASE_HEX;
        phase_next       = PH_DIGITS;
        done             = 1'b1;
      end else begin
        digit_base       = (active_base == '0) ? BASE_OCT : active_base;
        active_base_next = digit_base;
        p                = PH_DIGITS;
      end
    end

    if (!done && p == PH_DIGITS) begin
      if (dig.ok && dig.val < digit_base) begin
        act        = ACT_DIGIT;
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_STOP;
      end
    end
  end

  // Datapath update for the chosen action.
  always_comb begin
    logic [COUNT_WIDTH-1:0] count_inc;
    count_inc        = (char_count == '1) ? char_count : char_count + 1'b1;
    accumulator_next = accumulator;
    negate_flag_next = negate_flag;
    char_count_next  = char_count;
    unique case (act) inside
      ACT_NONE: begin
      end
      ACT_CONSUME, ACT_HEX: begin
        char_count_next = count_inc;
      end
      ACT_MINUS: begin
        negate_flag_next = 1'b1;
        char_count_next  = count_inc;
      end
      ACT_ZERO: begin
        accumulator_next = '0;
        char_count_next  = count_inc;
      end
      ACT_DIGIT: begin
        accumulator_next = accumulator * digit_base + VALUE_WIDTH'(dig.val);
        char_count_next  = count_inc;
      end
      default: begin
      end
    endcase
  end

  assign final_value           = negate_flag_next ? (-accumulator_next) : accumulator_next;
  assign count_wide            = 32'(char_count_next);
  assign result.value          = 64'(final_value);
  assign result.consumed_count = count_wide[15:0];

  assign status.phase      = phase;
  assign status.count_zero = (char_count == '0);

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_text)) begin
      phase       <= PH_WS1;
      active_base <= '0;
      accumulator <= '0;
      negate_flag <= 1'b0;
      char_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      active_base <= active_base_next;
      accumulator <= accumulator_next;
      negate_flag <= negate_flag_next;
      char_count  <= char_count_next;
    end
  end

endmodule

// File: rtl/core/tip_out_reg.sv
// Result register: holds one finished conversion until the consumer takes it.
module tip_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tip_pkg::tip_out_t load_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tip_pkg::tip_out_t out_data
);
  import tip_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// File: rtl/core/text_to_integer_parser_top.sv
// Top level of the streaming text-to-integer parser.
//
//  channel | signals                              | word
//  --------+--------------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data          | character, end_of_text
//  out     | out_valid, out_ready, out_data       | value, consumed_count
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | 0: number_base, 1: signed_mode
//
// One character word per cycle unless a waiting result stalls an end-of-text word;
// the end-of-text word goes to the input register, its result to the result register.
// The combinational multiply-add of accumulator by base sets the clock path.
// Reset (rst, synchronous) clears the parse state, number_base to 10 and
// signed_mode to 0. A waiting result stalls only an end-of-text word;
// characters keep flowing whenever the result register is free or being taken.
module text_to_integer_parser_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tip_pkg::tip_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tip_pkg::tip_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [5:0]        cfg_data
);
  import tip_pkg::*;

  tip_cfg_t    cfg;
  logic        q_valid;
  tip_in_t     q_data;
  logic        advance;
  logic        out_load;
  tip_out_t    result;
  tip_status_t status;

  // Config registers take writes any time; the host must write only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= BASE_DEC;
      cfg.signed_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE: cfg.number_base <= cfg_data;
        CFG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Advance the held character unless it ends a text and the result slot is stuck.
  assign advance  = q_valid && (!q_data.end_of_text || !out_valid || out_ready);
  assign out_load = advance && q_data.end_of_text;

  tip_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  tip_parse #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (q_data),
    .cfg    (cfg),
    .result (result),
    .status (status)
  );

  tip_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An end-of-text word that advances always leaves a result behind.
  a_eot_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("end-of-text word produced no result");

  // Parse state starts over after each result.
  a_eot_clears_state: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (status.phase == PH_WS1) && status.count_zero)
    else $error("parse state not cleared after end of text");

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(out_load && out_valid && !out_ready))
    else $error("result register overwritten while stalled");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the streaming text-to-integer parser.
module tb;
  import tip_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 90;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  tip_in_t           in_data    = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  tip_out_t          out_data;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index  = CFG_NUMBER_BASE;
  logic [5:0]        cfg_data   = '0;

  text_to_integer_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character words waiting for the driver, and conversions still owed by the block.
  tip_in_t  text_words[$];
  tip_out_t predicted_results[$];

  int  errors       = 0;
  int  in_idle_pct  = 0;
  int  out_stall_pct = 0;
  int  quiet_cycles = 0;
  logic hold_input  = 1'b0;
  logic in_fire     = 1'b0;

  // Shadow copy of the registers as the block should hold them.
  logic [5:0] base_reg   = BASE_DEC;
  logic       signed_reg = 1'b0;

  // Shadow parse state.
  tip_phase_t  phase_q = PH_WS1;
  logic [5:0]  radix_q = '0;
  logic [63:0] acc_q   = '0;
  logic        neg_q   = 1'b0;
  logic [15:0] count_q = '0;

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  function automatic logic blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  // Count saturates instead of wrapping.
  task automatic bump_count();
    if (count_q != '1) count_q = count_q + 16'd1;
  endtask

  // Fold one digit into the accumulator, or stop the parse on anything that
  // is not a digit of the current radix.
  task automatic accumulate_digit(input logic [7:0] c);
    logic       ok;
    logic [7:0] d;
    ok = 1'b1;
    d  = '0;
    if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + LETTER_OFFSET;
    else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + LETTER_OFFSET;
    else ok = 1'b0;
    if (ok && d < {2'b00, radix_q}) begin
      acc_q = acc_q * 64'(radix_q) + 64'(d);
      bump_count();
    end else begin
      phase_q = PH_STOP;
    end
  endtask

  // Advance the shadow parser by one character word. The early phases can
  // hand the same character on to the next phase, so they are chained ifs
  // guarded by "taken"; the radix phases are a plain case afterwards.
  task automatic step_parser(input tip_in_t w);
    logic [7:0] c;
    logic       taken;
    logic [5:0] b;
    tip_out_t   r;
    c     = w.character;
    taken = 1'b0;
    if (phase_q == PH_WS1) begin
      if (blank(c)) begin
        bump_count();
        taken = 1'b1;
      end else begin
        phase_q = PH_SIGN;
      end
    end
    if (!taken && phase_q == PH_SIGN) begin
      if (signed_reg) begin
        phase_q = PH_WS2;
        if (c == CH_MINUS) begin
          neg_q = 1'b1;
          bump_count();
          taken = 1'b1;
        end else if (c == CH_PLUS) begin
          bump_count();
          taken = 1'b1;
        end
      end else begin
        // Unsigned: only '+' is a sign, then straight on to the prefix.
        phase_q = PH_PREFIX;
        if (c == CH_PLUS) begin
          bump_count();
          taken = 1'b1;
        end
      end
    end
    if (!taken && phase_q == PH_WS2) begin
      if (blank(c)) begin
        bump_count();
        taken = 1'b1;
      end else begin
        phase_q = PH_PLUS2;
      end
    end
    if (!taken && phase_q == PH_PLUS2) begin
      phase_q = PH_PREFIX;
      if (c == CH_PLUS) begin
        bump_count();
        taken = 1'b1;
      end
    end
    if (!taken) begin
      case (phase_q)
        PH_PREFIX: begin
          // Latch the radix here; above 36 clamps to 36.
          b = (base_reg > BASE_MAX) ? BASE_MAX : base_reg;
          radix_q = b;
          if (c == CH_0 && (b == 6'd0 || b == BASE_HEX)) begin
            acc_q = '0;
            bump_count();
            phase_q = PH_ZERO;
          end else begin
            if (radix_q == 6'd0) radix_q = BASE_DEC;
            phase_q = PH_DIGITS;
            accumulate_digit(c);
          end
        end
        PH_ZERO: begin
          phase_q = PH_DIGITS;
          if (c == CH_LX || c == CH_UX) begin
            radix_q = BASE_HEX;
            bump_count();
          end else begin
            if (radix_q == 6'd0) radix_q = BASE_OCT;
            accumulate_digit(c);
          end
        end
        PH_DIGITS: accumulate_digit(c);
        default: ;  // stopped: ignore until end of text
      endcase
    end
    if (w.end_of_text) begin
      r.value          = neg_q ? 64'd0 - acc_q : acc_q;
      r.consumed_count = count_q;
      predicted_results.push_back(r);
      phase_q = PH_WS1;
      radix_q = '0;
      acc_q   = '0;
      neg_q   = 1'b0;
      count_q = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  // Letters come out in either case.
  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  // Queue a conversion; the last character carries the end-of-text mark.
  task automatic push_text(input logic [7:0] text[$]);
    tip_in_t w;
    foreach (text[i]) begin
      w.character   = text[i];
      w.end_of_text = (i == text.size() - 1);
      text_words.push_back(w);
    end
  endtask

  task automatic queue_string(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    push_text(text);
  endtask

  // One random conversion shaped for the current register settings: mostly
  // well-formed (blanks, signs, prefix, digits of the right radix) with a
  // tail of junk now and then, and a share of pure byte noise.
  task automatic queue_text();
    logic [7:0]  text[$];
    int unsigned eff;
    int unsigned digit_radix;
    int unsigned ndig;
    int unsigned roll;
    eff  = 32'((base_reg > BASE_MAX) ? BASE_MAX : base_reg);
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
      roll = $urandom_range(99);
      if (signed_reg) begin
        if (roll < 40) text.push_back(CH_MINUS);
        else if (roll < 60) text.push_back(CH_PLUS);
        repeat ($urandom_range(0, 1)) text.push_back(pick_blank());
        if ($urandom_range(3) == 0) text.push_back(CH_PLUS);
      end else if (roll < 20) begin
        text.push_back(CH_PLUS);
      end else if (roll < 25) begin
        text.push_back(CH_MINUS);  // refused without signed mode
      end
      digit_radix = (eff == 0) ? 32'(BASE_DEC) : eff;
      if ((eff == 0 || eff == 32'(BASE_HEX)) && $urandom_range(2) != 0) begin
        text.push_back(CH_0);
        if ($urandom_range(3) != 0) begin
          text.push_back($urandom_range(1) ? CH_LX : CH_UX);
          digit_radix = 32'(BASE_HEX);
        end else if (eff == 0) begin
          digit_radix = 32'(BASE_OCT);
        end
      end
      ndig = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 24);
      repeat (ndig) text.push_back(digit_char($urandom_range(digit_radix - 1)));
      if ($urandom_range(2) == 0)
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
    end
    if (text.size() == 0) text.push_back(8'($urandom_range(255)));
    push_text(text);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes and phase control
  // ---------------------------------------------------------------------------

  // Drive one register word and hold it until the block takes it.
  task automatic write_reg(input logic [0:0] idx, input logic [5:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUMBER_BASE) base_reg = data;
    else signed_reg = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every word is in and every result is out, then let the
  // two-stage pipeline settle before touching the registers.
  task automatic drain();
    while (text_words.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 88; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 88; end
      default: begin in_idle_pct = 35; out_stall_pct = 35; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next word at the falling edge, hold it until taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (text_words.size() != 0 && !hold_input && $urandom_range(99) >= in_idle_pct) begin
        in_data  <= text_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted character, check every accepted result.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    tip_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) step_parser(in_data);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $error("unexpected result: value %h, consumed_count %0d",
                 out_data.value, out_data.consumed_count);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.value !== want.value) begin
            errors++;
            $error("value: expected %h, got %h", want.value, out_data.value);
          end
          if (out_data.consumed_count !== want.consumed_count) begin
            errors++;
            $error("consumed_count: expected %0d, got %0d",
                   want.consumed_count, out_data.consumed_count);
          end
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[text_to_integer_parser_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------

  logic [5:0]  base_plan[PHASES] = '{6'd10, 6'd0, 6'd16, 6'd1, 6'd36,
                                     6'd63, 6'd2, 6'd8, 6'd0, 6'd37};
  logic        sign_plan[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                     1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed texts at reset settings (base 10, unsigned): blank skipping
    // and '+', a refused '-', the top byte and the zero byte as lone stops.
    queue_string(" \t\n+907");
    queue_string("-5");
    queue_string("\377");
    push_text('{8'h00});
    drain();

    // Automatic radix with signed mode: '-', a second blank run and a
    // second '+', then a hex prefix; a prefix with no digits; octal.
    write_reg(CFG_NUMBER_BASE, 6'd0);
    write_reg(CFG_SIGNED_MODE, 6'd1);
    queue_string("-\t+0x1f");
    queue_string("0xg");
    queue_string("017");
    drain();

    // Random phases, each with its own register setting and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_NUMBER_BASE, base_plan[p]);
      write_reg(CFG_SIGNED_MODE, {5'($urandom_range(31)), sign_plan[p]});
      set_idling(p % 4);
      while (text_words.size() < PHASE_WORDS) queue_text();
      if (p == 1) begin
        // Hold the sender mid-phase until the block has nothing owed.
        while (text_words.size() > PHASE_WORDS / 2) @(posedge clk);
        hold_input = 1'b1;
        while (in_valid || predicted_results.size() != 0) @(posedge clk);
        hold_input = 1'b0;
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("[text_to_integer_parser_top] OK");
    end else begin
      $display("[text_to_integer_parser_top] ERROR");
    end
    $finish;
  end

endmodule
